/* rtl/core/sgcf_pkg.sv */
// Shared types, constants and register codes for the servo goal block.
// Used by every module under rtl/core; depends on nothing.

package sgcf_pkg;

   // Defaults for the top-level parameters
   localparam int NUM_MOTORS_DEF  = 4;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Port widths
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 3;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   // Rate limiter
   localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

   // Ticks = round(scale * angle / 5760); 5760 = 45 * 128
   localparam logic [33:0] ROUND_BIAS = 34'd2880;
   localparam int          DIV_SHIFT  = 7;
   localparam logic [26:0] DIV_ODD    = 27'd45;
   localparam logic [26:0] RECIP_ODD  = 27'd95443717;  // floor(2^32 / 45)

   // Register reset values
   localparam logic [1:0]         MODE_RST      = 2'd3;
   localparam logic signed [15:0] SCALE_RST     = 16'sd5120;
   localparam logic signed [31:0] MIN_GOAL_RST  = -32'sd1048575;
   localparam logic signed [31:0] MAX_GOAL_RST  = 32'sd1048575;
   localparam logic [15:0]        PERIOD_RST    = 16'd10;
   localparam logic [3:0]         MASK_RST      = 4'hF;
   localparam logic [63:0]        OFFSETS_RST   = 64'd0;

   typedef enum logic [1:0] {
      REQ_ANGLE   = 2'd0,
      REQ_CONTACT = 2'd1,
      REQ_TICK    = 2'd2,
      REQ_LOAD    = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_MODE_FLAGS    = 3'd0,
      REG_ROLL_GAIN     = 3'd1,
      REG_MIN_GOAL      = 3'd2,
      REG_MAX_GOAL      = 3'd3,
      REG_MIN_PERIOD    = 3'd4,
      REG_MOTOR_MASK    = 3'd5,
      REG_MOTOR_OFFSETS = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RND,
      ST_RECIP,
      ST_FIX,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         mode_flags;
      logic signed [15:0] roll_gain;
      logic signed [31:0] min_goal;
      logic signed [31:0] max_goal;
      logic [15:0]        min_period_ticks;
      logic [3:0]         motor_mask;
      logic [63:0]        motor_offsets;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         motor_index;
      logic signed [31:0] goal_position;
      logic               frozen;
      logic               last_in_run;
   } beat_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

/* rtl/core/sgcf_csr.sv */
// Configuration register file with an APB-style write/read port.
// Depends on sgcf_pkg for register codes, reset values and cfg_type.

module sgcf_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sgcf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sgcf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sgcf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output sgcf_pkg::cfg_type                cfg
);

   sgcf_pkg::cfg_type       cfg_ff;
   sgcf_pkg::csr_index_type reg_sel;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = sgcf_pkg::csr_index_type'(csr_paddr[5:3]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode_flags       <= sgcf_pkg::MODE_RST;
         cfg_ff.roll_gain        <= sgcf_pkg::SCALE_RST;
         cfg_ff.min_goal         <= sgcf_pkg::MIN_GOAL_RST;
         cfg_ff.max_goal         <= sgcf_pkg::MAX_GOAL_RST;
         cfg_ff.min_period_ticks <= sgcf_pkg::PERIOD_RST;
         cfg_ff.motor_mask       <= sgcf_pkg::MASK_RST;
         cfg_ff.motor_offsets    <= sgcf_pkg::OFFSETS_RST;
      end else if (wr_en) begin
         case (reg_sel)
            sgcf_pkg::REG_MODE_FLAGS:    cfg_ff.mode_flags       <= csr_pwdata[1:0];
            sgcf_pkg::REG_ROLL_GAIN:     cfg_ff.roll_gain        <= $signed(csr_pwdata[15:0]);
            sgcf_pkg::REG_MIN_GOAL:      cfg_ff.min_goal         <= $signed(csr_pwdata[31:0]);
            sgcf_pkg::REG_MAX_GOAL:      cfg_ff.max_goal         <= $signed(csr_pwdata[31:0]);
            sgcf_pkg::REG_MIN_PERIOD:    cfg_ff.min_period_ticks <= csr_pwdata[15:0];
            sgcf_pkg::REG_MOTOR_MASK:    cfg_ff.motor_mask       <= csr_pwdata[3:0];
            sgcf_pkg::REG_MOTOR_OFFSETS: cfg_ff.motor_offsets    <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         sgcf_pkg::REG_MODE_FLAGS:    csr_prdata = 64'(cfg_ff.mode_flags);
         sgcf_pkg::REG_ROLL_GAIN:     csr_prdata = {48'd0, cfg_ff.roll_gain};
         sgcf_pkg::REG_MIN_GOAL:      csr_prdata = {32'd0, cfg_ff.min_goal};
         sgcf_pkg::REG_MAX_GOAL:      csr_prdata = {32'd0, cfg_ff.max_goal};
         sgcf_pkg::REG_MIN_PERIOD:    csr_prdata = 64'(cfg_ff.min_period_ticks);
         sgcf_pkg::REG_MOTOR_MASK:    csr_prdata = 64'(cfg_ff.motor_mask);
         sgcf_pkg::REG_MOTOR_OFFSETS: csr_prdata = cfg_ff.motor_offsets;
         default:                     csr_prdata = '0;
      endcase
   end

endmodule

/* rtl/core/sgcf_front.sv */
// Front end: accepts request beats, keeps the servo state, runs the rate
// limiter and scaling sequence, and pushes goal beats into the queue.
// Depends on sgcf_pkg.

module sgcf_front #(
   parameter int NUM_MOTORS = sgcf_pkg::NUM_MOTORS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sgcf_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic [sgcf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  sgcf_pkg::cfg_type                cfg,
   input  sgcf_pkg::queue_stat_type         q_stat,
   output logic                             q_push,
   output sgcf_pkg::beat_type               q_beat
);

   localparam int MIW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
   localparam logic [MIW-1:0] LAST_M = MIW'(NUM_MOTORS - 1);

   sgcf_pkg::state_type    state_ff, state_in;
   sgcf_pkg::req_kind_type kind;

   // Servo state
   logic                have_angle_ff, have_contact_ff, zero_captured_ff, goal_valid_ff;
   logic signed [16:0]  stored_angle_ff, zero_angle_ff;
   logic [15:0]         elapsed_ff;
   logic                in_contact_ff [NUM_MOTORS];
   logic signed [31:0]  hold_ff       [NUM_MOTORS];
   logic signed [31:0]  base_ff       [NUM_MOTORS];
   logic signed [31:0]  prev_ff       [NUM_MOTORS];

   // Scaling sequence
   logic signed [17:0]  d_ff;
   logic signed [33:0]  p_ff;
   logic [26:0]         x_ff;
   logic [21:0]         q0_ff;
   logic                neg_ff;
   logic signed [31:0]  delta_ff;
   logic [MIW-1:0]      m_ff;

   // Request fields
   logic signed [16:0]  roll_angle;
   logic [3:0]          contact_flags;
   logic [1:0]          load_motor;
   logic signed [31:0]  load_position;

   logic                accept, run_ok, capture, run_go, step;
   logic signed [16:0]  angle_eff;
   logic                ha_eff, hc_eff;
   logic [15:0]         el_eff;
   logic signed [17:0]  ext_zero, ext_ang, d_in;
   logic [7:0]          mask8, flags8;
   logic [NUM_MOTORS-1:0] conn_vec;
   logic                later_any;
   logic [3:0]          idx_w;
   logic [1:0]          idx2;
   logic signed [15:0]  off_cur;
   logic signed [31:0]  sum_cur, goal_cur;
   logic [33:0]         ap;
   logic [33:0]         biased;
   logic [53:0]         recip_prod;
   logic [26:0]         q0_times;
   logic [26:0]         rem;
   logic [21:0]         q_fix;

   assign roll_angle    = $signed(req_tdata[16:0]);
   assign contact_flags = req_tdata[20:17];
   assign load_motor    = req_tdata[22:21];
   assign load_position = $signed(req_tdata[54:23]);
   assign kind          = sgcf_pkg::req_kind_type'(req_tuser);

   assign req_tready = (state_ff == sgcf_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign mask8  = {4'd0, cfg.motor_mask};
   assign flags8 = {4'd0, contact_flags};

   always_comb begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
         conn_vec[k] = mask8[k];
      end
   end

   // Run decision
   always_comb begin
      angle_eff = (kind == sgcf_pkg::REQ_ANGLE) ? roll_angle : stored_angle_ff;
      ha_eff    = have_angle_ff || (kind == sgcf_pkg::REQ_ANGLE);
      hc_eff    = have_contact_ff || (kind == sgcf_pkg::REQ_CONTACT);
      el_eff    = (kind == sgcf_pkg::REQ_CONTACT) ? sgcf_pkg::ELAPSED_MAX : elapsed_ff;
      run_ok    = accept
                  && ((kind == sgcf_pkg::REQ_ANGLE) || (kind == sgcf_pkg::REQ_CONTACT))
                  && ha_eff && hc_eff && (cfg.motor_mask != 4'd0)
                  && (el_eff >= cfg.min_period_ticks);
      capture   = run_ok && cfg.mode_flags[0] && !zero_captured_ff;
      run_go    = run_ok && !capture;
      ext_zero  = {zero_angle_ff[16], zero_angle_ff};
      ext_ang   = {angle_eff[16], angle_eff};
      d_in      = cfg.mode_flags[0] ? (ext_zero - ext_ang) : -ext_ang;
   end

   // Division datapath pieces
   always_comb begin
      ap         = p_ff[33] ? 34'(-p_ff) : 34'(p_ff);
      biased     = ap + sgcf_pkg::ROUND_BIAS;
      recip_prod = 54'(x_ff) * 54'(sgcf_pkg::RECIP_ODD);
      q0_times   = 27'(q0_ff) * sgcf_pkg::DIV_ODD;
      rem        = x_ff - q0_times;
      q_fix      = (rem >= sgcf_pkg::DIV_ODD) ? (q0_ff + 22'd1) : q0_ff;
   end

   // Goal for the motor under the emit counter
   always_comb begin
      idx_w    = 4'(m_ff);
      idx2     = idx_w[1:0];
      off_cur  = $signed(cfg.motor_offsets[{idx2, 4'b0000} +: 16]);
      sum_cur  = base_ff[m_ff] + 32'(off_cur) + delta_ff;
      goal_cur = sum_cur;
      if (cfg.mode_flags[1]) begin
         if (goal_cur > cfg.max_goal) goal_cur = cfg.max_goal;
         if (goal_cur < cfg.min_goal) goal_cur = cfg.min_goal;
      end
      if (in_contact_ff[m_ff]) begin
         goal_cur = hold_ff[m_ff];
      end
      later_any = 1'b0;
      for (int k = 0; k < NUM_MOTORS; k++) begin
         if (conn_vec[k] && (MIW'(k) > m_ff)) later_any = 1'b1;
      end
      q_beat.motor_index   = idx2;
      q_beat.goal_position = goal_cur;
      q_beat.frozen        = in_contact_ff[m_ff];
      q_beat.last_in_run   = !later_any;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sgcf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      q_push   = 1'b0;
      step     = 1'b0;
      case (state_ff)
         sgcf_pkg::ST_IDLE: begin
            if (run_go) state_in = sgcf_pkg::ST_MUL;
         end
         sgcf_pkg::ST_MUL:   state_in = sgcf_pkg::ST_RND;
         sgcf_pkg::ST_RND:   state_in = sgcf_pkg::ST_RECIP;
         sgcf_pkg::ST_RECIP: state_in = sgcf_pkg::ST_FIX;
         sgcf_pkg::ST_FIX:   state_in = sgcf_pkg::ST_EMIT;
         sgcf_pkg::ST_EMIT: begin
            q_push = conn_vec[m_ff] && !q_stat.full;
            step   = !conn_vec[m_ff] || !q_stat.full;
            if (step && (m_ff == LAST_M)) state_in = sgcf_pkg::ST_IDLE;
         end
         default: state_in = sgcf_pkg::ST_IDLE;
      endcase
   end

   // Servo state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         have_angle_ff    <= 1'b0;
         have_contact_ff  <= 1'b0;
         zero_captured_ff <= 1'b0;
         goal_valid_ff    <= 1'b0;
         stored_angle_ff  <= '0;
         zero_angle_ff    <= '0;
         elapsed_ff       <= sgcf_pkg::ELAPSED_MAX;
         for (int k = 0; k < NUM_MOTORS; k++) begin
            in_contact_ff[k] <= 1'b0;
            hold_ff[k]       <= '0;
            base_ff[k]       <= '0;
            prev_ff[k]       <= '0;
         end
      end else begin
         if (accept) begin
            case (kind)
               sgcf_pkg::REQ_ANGLE: begin
                  stored_angle_ff <= roll_angle;
                  have_angle_ff   <= 1'b1;
                  if (run_ok) elapsed_ff <= '0;
               end
               sgcf_pkg::REQ_CONTACT: begin
                  have_contact_ff <= 1'b1;
                  // Re-arm the limiter, then clear it if the run goes ahead
                  elapsed_ff      <= run_ok ? 16'd0 : sgcf_pkg::ELAPSED_MAX;
                  for (int k = 0; k < NUM_MOTORS; k++) begin
                     if (conn_vec[k]) begin
                        in_contact_ff[k] <= flags8[k];
                        if (flags8[k] && !in_contact_ff[k]) begin
                           hold_ff[k] <= goal_valid_ff ? prev_ff[k] : base_ff[k];
                        end
                     end
                  end
               end
               sgcf_pkg::REQ_TICK: begin
                  if (elapsed_ff != sgcf_pkg::ELAPSED_MAX) elapsed_ff <= elapsed_ff + 16'd1;
               end
               sgcf_pkg::REQ_LOAD: begin
                  for (int k = 0; k < NUM_MOTORS; k++) begin
                     if (3'(k) == {1'b0, load_motor}) begin
                        base_ff[k] <= load_position;
                        hold_ff[k] <= load_position;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (capture) begin
            zero_angle_ff    <= angle_eff;
            zero_captured_ff <= 1'b1;
         end
         if (q_push) prev_ff[m_ff] <= goal_cur;
         if (step && (m_ff == LAST_M)) goal_valid_ff <= 1'b1;
      end
   end

   // Scaling sequence registers
   always_ff @(posedge clock) begin
      if (run_go) d_ff <= d_in;
      if (state_ff == sgcf_pkg::ST_MUL) p_ff <= cfg.roll_gain * d_ff;
      if (state_ff == sgcf_pkg::ST_RND) begin
         x_ff   <= 27'(biased >> sgcf_pkg::DIV_SHIFT);
         neg_ff <= p_ff[33];
      end
      if (state_ff == sgcf_pkg::ST_RECIP) q0_ff <= recip_prod[53:32];
      if (state_ff == sgcf_pkg::ST_FIX) begin
         delta_ff <= neg_ff ? -$signed(32'(q_fix)) : $signed(32'(q_fix));
         m_ff     <= '0;
      end
      if (step) m_ff <= m_ff + 1'b1;
   end

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("goal pushed into a full queue");

   a_delta_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sgcf_pkg::ST_EMIT) |-> ((delta_ff[31:21] == '0) || (delta_ff[31:21] == '1)))
      else $error("scaled angle out of range");

   a_valid_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(goal_valid_ff) |-> $past(state_ff == sgcf_pkg::ST_EMIT))
      else $error("goal_valid set outside a command run");

   a_zero_first: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sgcf_pkg::ST_EMIT) && cfg.mode_flags[0]) |-> zero_captured_ff)
      else $error("goals emitted before zero angle captured");

endmodule

/* rtl/core/sgcf_queue.sv */
// Small goal queue between the front end and the output stage.
// Depends on sgcf_pkg for beat_type and queue_stat_type.

module sgcf_queue #(
   parameter int DEPTH = sgcf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  sgcf_pkg::beat_type       push_beat,
   input  logic                     pop,
   output sgcf_pkg::beat_type       head,
   output sgcf_pkg::queue_stat_type stat
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
   localparam logic [PW:0]   FULL_CNT  = (PW + 1)'(DEPTH);

   sgcf_pkg::beat_type slot_ff [DEPTH];
   logic [PW-1:0]      wr_ff, rd_ff;
   logic [PW:0]        count_ff;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_beat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == LAST_SLOT) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

endmodule

/* rtl/core/sgcf_back.sv */
// Output stage: pops goal beats from the queue into the response register.
// Depends on sgcf_pkg for beat_type and queue_stat_type.

module sgcf_back (
   input  logic                             clock,
   input  logic                             reset,
   input  sgcf_pkg::beat_type               head,
   input  sgcf_pkg::queue_stat_type         q_stat,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sgcf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [sgcf_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                             rsp_tlast
);

   logic               valid_ff;
   sgcf_pkg::beat_type beat_ff;

   // Refill when the register is empty or its beat leaves this cycle
   assign pop = !q_stat.empty && (!valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) beat_ff <= head;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = beat_ff.goal_position;
   assign rsp_tuser  = {beat_ff.frozen, beat_ff.motor_index};
   assign rsp_tlast  = beat_ff.last_in_run;

endmodule

/* rtl/core/servo_goal_with_contact_freeze.sv */
// Top level of the servo goal generator with contact freeze.
// Instantiates sgcf_csr, sgcf_front, sgcf_queue and sgcf_back; uses sgcf_pkg.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  req_     | in        | tuser = kind; tdata = angle, contacts, motor, position
//  rsp_     | out       | tuser = motor, frozen; tdata = goal; tlast = end of run
//  csr_     | in/out    | APB-style registers at byte address 8*i, 64-bit data
//
// Sequence: angle samples, contact updates that start no run, ticks and base loads
// only update the servo state. A command run goes through accept, four steps
// of the scaling sequence (multiply, round, reciprocal multiply, fix), then one
// motor slot per cycle while goals are pushed into the queue and it is not full.
// Reset: synchronous; clears all servo state, the queue and the output register,
// and loads the register defaults.
// Stalls: a full queue holds the emit step on the current motor; the input side
// waits until the run in progress has stepped through its last motor slot.

module servo_goal_with_contact_freeze #(
   parameter int NUM_MOTORS  = sgcf_pkg::NUM_MOTORS_DEF,
   parameter int QUEUE_DEPTH = sgcf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // tuser: req_type[1:0]
   // tdata: roll_angle[16:0], contact_flags[20:17], load_motor[22:21],
   //        load_position[54:23], zero pad[55]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sgcf_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic [sgcf_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: motor_index[1:0], frozen[2]
   // tdata: goal_position[31:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sgcf_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic [sgcf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sgcf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sgcf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sgcf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   sgcf_pkg::cfg_type        cfg;
   sgcf_pkg::queue_stat_type q_stat;
   sgcf_pkg::beat_type       push_beat, head;
   logic                     push, pop;

   // Register file
   sgcf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Intake, state, limiter and goal math
   sgcf_front #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cfg        (cfg),
      .q_stat     (q_stat),
      .q_push     (push),
      .q_beat     (push_beat)
   );

   // Decouple goal generation from the response handshake
   sgcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .pop       (pop),
      .head      (head),
      .stat      (q_stat)
   );

   // Response register
   sgcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* bench/sgcf_goal_checker.sv */
// Goal checker for the servo goal block: watches the request, goal and register ports,
// predicts every goal beat and compares it field by field with what the block sends.
// Depends on sgcf_pkg for port widths, request kinds, register indexes and the goal beat type.

module sgcf_goal_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [sgcf_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic [sgcf_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [sgcf_pkg::RSP_USER_W-1:0]  rsp_tuser,
   input  logic [sgcf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sgcf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sgcf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  logic                             csr_pready,
   output int                               mismatches,
   output int                               pending,
   output int                               goals_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MOTORS = sgcf_pkg::NUM_MOTORS_DEF;

   // register copy
   logic [1:0]         mode_r;
   logic signed [15:0] scale_r;
   logic signed [31:0] clamp_lo, clamp_hi;
   logic [15:0]        period_r;
   logic [3:0]         mask_r;
   logic [63:0]        offsets_r;

   // servo state
   logic               angle_seen, contacts_seen, zero_taken, goals_issued;
   logic signed [16:0] last_angle, zero_ref;
   logic [3:0]         touching;
   logic signed [31:0] held [MOTORS];
   logic signed [31:0] base [MOTORS];
   logic signed [31:0] last_goal [MOTORS];
   logic [15:0]        ticks_since;

   sgcf_pkg::beat_type     goals_due [$];
   sgcf_pkg::beat_type     want, got;
   sgcf_pkg::req_kind_type kind;
   logic [3:0]             flags;
   logic [1:0]             slot;

   task automatic flag_field(input string field, input longint exp_v, input longint got_v);
      mismatches++;
      if (mismatches <= 40)
         $display("t=%0t goal beat %s mismatch: expected %0d, got %0d",
                  $time, field, exp_v, got_v);
   endtask

   // One command run: rate limit, optional zero capture, then one goal per connected motor.
   task automatic command_run();
      longint             diff, prod, mag, steps, wide;
      logic signed [31:0] goal;
      int                 last_m;
      sgcf_pkg::beat_type b;
      if (!angle_seen || !contacts_seen || mask_r == 4'd0) return;
      if (ticks_since < period_r) return;
      ticks_since = 16'd0;
      if (mode_r[0] && !zero_taken) begin
         zero_ref   = last_angle;
         zero_taken = 1'b1;
         return;
      end
      diff  = mode_r[0] ? longint'(zero_ref) - longint'(last_angle) : -longint'(last_angle);
      prod  = longint'(scale_r) * diff;
      mag   = (prod < 0) ? -prod : prod;
      steps = (mag + 2880) / 5760;           // halves round away from zero
      if (prod < 0) steps = -steps;
      last_m = 0;
      for (int m = 0; m < MOTORS; m++)
         if (mask_r[m]) last_m = m;
      for (int m = 0; m < MOTORS; m++) begin
         if (!mask_r[m]) continue;
         if (touching[m]) begin
            goal = held[m];
         end else begin
            wide = longint'(base[m]) + longint'($signed(offsets_r[16*m +: 16])) + steps;
            goal = wide[31:0];
            if (mode_r[1]) begin
               if (goal > clamp_hi) goal = clamp_hi;
               if (goal < clamp_lo) goal = clamp_lo;   // inverted window lands on the floor
            end
         end
         last_goal[m]    = goal;
         b.motor_index   = 2'(m);
         b.goal_position = goal;
         b.frozen        = touching[m];
         b.last_in_run   = (m == last_m);
         goals_due.push_back(b);
      end
      goals_issued = 1'b1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_r        = sgcf_pkg::MODE_RST;
         scale_r       = sgcf_pkg::SCALE_RST;
         clamp_lo      = sgcf_pkg::MIN_GOAL_RST;
         clamp_hi      = sgcf_pkg::MAX_GOAL_RST;
         period_r      = sgcf_pkg::PERIOD_RST;
         mask_r        = sgcf_pkg::MASK_RST;
         offsets_r     = sgcf_pkg::OFFSETS_RST;
         angle_seen    = 1'b0;
         contacts_seen = 1'b0;
         zero_taken    = 1'b0;
         goals_issued  = 1'b0;
         last_angle    = '0;
         zero_ref      = '0;
         touching      = '0;
         ticks_since   = sgcf_pkg::ELAPSED_MAX;
         for (int m = 0; m < MOTORS; m++) begin
            held[m]      = '0;
            base[m]      = '0;
            last_goal[m] = '0;
         end
         goals_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.motor_index   = rsp_tuser[1:0];
            got.frozen        = rsp_tuser[2];
            got.goal_position = rsp_tdata;
            got.last_in_run   = rsp_tlast;
            goals_seen++;
            if (goals_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 40)
                  $display("t=%0t goal beat with none expected: motor %0d goal %0d",
                           $time, got.motor_index, got.goal_position);
            end else begin
               want = goals_due.pop_front();
               if (got.motor_index !== want.motor_index)
                  flag_field("motor_index", want.motor_index, got.motor_index);
               if (got.goal_position !== want.goal_position)
                  flag_field("goal_position", want.goal_position, got.goal_position);
               if (got.frozen !== want.frozen)
                  flag_field("frozen", want.frozen, got.frozen);
               if (got.last_in_run !== want.last_in_run)
                  flag_field("last_in_run", want.last_in_run, got.last_in_run);
            end
         end

         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            case (sgcf_pkg::csr_index_type'(csr_paddr[5:3]))
               sgcf_pkg::REG_MODE_FLAGS:    mode_r    = csr_pwdata[1:0];
               sgcf_pkg::REG_ROLL_GAIN:     scale_r   = csr_pwdata[15:0];
               sgcf_pkg::REG_MIN_GOAL:      clamp_lo  = csr_pwdata[31:0];
               sgcf_pkg::REG_MAX_GOAL:      clamp_hi  = csr_pwdata[31:0];
               sgcf_pkg::REG_MIN_PERIOD:    period_r  = csr_pwdata[15:0];
               sgcf_pkg::REG_MOTOR_MASK:    mask_r    = csr_pwdata[3:0];
               sgcf_pkg::REG_MOTOR_OFFSETS: offsets_r = csr_pwdata;
               default: ;
            endcase

         if (req_tvalid && req_tready) begin
            kind = sgcf_pkg::req_kind_type'(req_tuser);
            case (kind)
               sgcf_pkg::REQ_ANGLE: begin
                  last_angle = req_tdata[16:0];
                  angle_seen = 1'b1;
                  command_run();
               end
               sgcf_pkg::REQ_CONTACT: begin
                  flags         = req_tdata[20:17];
                  contacts_seen = 1'b1;
                  for (int m = 0; m < MOTORS; m++)
                     if (mask_r[m]) begin
                        if (flags[m] && !touching[m])
                           held[m] = goals_issued ? last_goal[m] : base[m];
                        touching[m] = flags[m];
                     end
                  ticks_since = sgcf_pkg::ELAPSED_MAX;   // contact re-arms the limiter
                  command_run();
               end
               sgcf_pkg::REQ_TICK: begin
                  if (ticks_since != sgcf_pkg::ELAPSED_MAX) ticks_since = ticks_since + 16'd1;
               end
               default: begin
                  slot       = req_tdata[22:21];
                  base[slot] = req_tdata[54:23];
                  held[slot] = req_tdata[54:23];
               end
            endcase
         end
      end
      pending = goals_due.size();
   end

endmodule

/* bench/servo_goal_with_contact_freeze_tb.sv */
// Top of the servo goal bench: clock, reset, request and register stimulus, goal-side
// back-pressure and the verdict. Depends on sgcf_pkg, the block and sgcf_goal_checker.

module servo_goal_with_contact_freeze_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Generous ceiling on the length of the whole simulation.
   localparam int LIMIT_CYCLES    = 250000;
   // A run passes the block's accept, scaling and emit states, the goal queue and output register;
   // wait this long after the last goal so a silent zero-capture run is over too.
   localparam int DRAIN_CYCLES    = 32;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 74;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_tvalid  = 1'b0;
   logic                            req_tready;
   logic [sgcf_pkg::REQ_USER_W-1:0] req_tuser   = '0;
   logic [sgcf_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready  = 1'b1;
   logic [sgcf_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic [sgcf_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tlast;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [sgcf_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [sgcf_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [sgcf_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int   mismatches, pending, goals_seen;
   int   sent_beats = 0;
   int   settings   = 1;     // the reset defaults count as the first setting
   int   cycles     = 0;
   int   stall_left = 0;
   logic calm       = 1'b0;  // set for the final phase: no idling on either side

   servo_goal_with_contact_freeze dut (.*);
   sgcf_goal_checker goal_check (.*);

   always #2 clock = ~clock;

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("servo_goal_with_contact_freeze_tb: errors");
         $finish;
      end
   end

   // Goal-side back-pressure: drop ready at random for bursts of random length,
   // hold it high during reset and through the calm phase.
   always @(negedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else if (!calm && !reset && $urandom_range(0, 5) == 0)
         stall_left = $urandom_range(1, 6);
      rsp_tready <= (stall_left == 0);
   end

   // Offer one request beat and hold it until the block takes it. Outside the calm
   // phase, idle the request side first for a random burst now and then.
   task automatic put_beat(input sgcf_pkg::req_kind_type kind, input logic [16:0] angle,
                           input logic [3:0] flags, input logic [1:0] motor,
                           input logic [31:0] pos);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, pos, motor, flags, angle};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_beats++;
   endtask

   // Fields a kind does not use carry junk, so the block must ignore them.
   task automatic send_angle(input int deg256);
      put_beat(sgcf_pkg::REQ_ANGLE, deg256[16:0], 4'($urandom), 2'($urandom), $urandom);
   endtask

   task automatic send_contact(input logic [3:0] flags);
      put_beat(sgcf_pkg::REQ_CONTACT, 17'($urandom), flags, 2'($urandom), $urandom);
   endtask

   task automatic send_tick();
      put_beat(sgcf_pkg::REQ_TICK, 17'($urandom), 4'($urandom), 2'($urandom), $urandom);
   endtask

   task automatic send_load(input logic [1:0] motor, input logic [31:0] pos);
      put_beat(sgcf_pkg::REQ_LOAD, 17'($urandom), 4'($urandom), motor, pos);
   endtask

   // Drop valid, wait for every predicted goal, then let the block finish any
   // run that emits nothing.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Register write: setup cycle, then access cycle until pready.
   task automatic csr_write(input sgcf_pkg::csr_index_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Reprogram every register, only once the block has gone quiet.
   task automatic set_config(input logic [1:0] mode, input logic [15:0] scale,
                             input logic [31:0] lo, input logic [31:0] hi,
                             input logic [15:0] period, input logic [3:0] mask,
                             input logic [63:0] offsets);
      settle();
      csr_write(sgcf_pkg::REG_MODE_FLAGS, 64'(mode));
      csr_write(sgcf_pkg::REG_ROLL_GAIN, 64'(scale));
      csr_write(sgcf_pkg::REG_MIN_GOAL, 64'(lo));
      csr_write(sgcf_pkg::REG_MAX_GOAL, 64'(hi));
      csr_write(sgcf_pkg::REG_MIN_PERIOD, 64'(period));
      csr_write(sgcf_pkg::REG_MOTOR_MASK, 64'(mask));
      csr_write(sgcf_pkg::REG_MOTOR_OFFSETS, offsets);
      settings++;
   endtask

   initial begin
      int          pick, roll;
      logic [1:0]  mode;
      logic [15:0] scale, period;
      logic [31:0] lo, hi;
      logic [3:0]  mask;
      logic [63:0] offsets;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Defaults: zero capture and clamping on, ten ticks between runs.
      // Bases at the 32-bit extremes so the wrapped sum gets clamped.
      send_load(2'd0, 32'h7FFF_FFFF);
      send_load(2'd1, 32'h8000_0000);
      send_angle(46080);            // angle alone: no contact data yet, no run
      send_contact(4'b0000);        // first run only captures the zero angle
      send_angle(-46080);           // limiter just cleared: held off
      repeat (10) send_tick();
      send_angle(-46080);           // full-scale swing, all four motors
      send_contact(4'b0101);        // rising contact freezes at the last goal
      send_contact(4'b1111);
      send_load(2'd0, 32'd5);       // load while in contact moves the held goal
      send_contact(4'b1110);        // motor 0 released, back on base + delta

      // Inverted clamp window, longest period, odd motors only, extreme offsets.
      set_config(2'b10, 16'h7FFF, 32'd500, -32'sd500, 16'hFFFF, 4'b1010,
                 64'h7FFF_8000_7FFF_8000);
      send_contact(4'b0000);        // saturated counter passes even a 65535 period
      send_tick();
      send_angle(17);               // one tick is far short of the period
      send_contact(4'b1010);

      // Plain offsets, no clamp, no limit; a scale of 45 makes exact halves.
      set_config(2'b00, 16'd45, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 4'b0111, 64'd0);
      send_contact(4'b0000);
      send_angle(64);               // -0.5 tick rounds to -1
      send_angle(-64);              // +0.5 tick rounds to +1
      send_angle(0);

      // Random phases: each gets a fresh register setting with the extremes
      // spread across phases, then a mix weighted toward angle samples and ticks
      // so runs keep passing the limiter.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode = 2'($urandom_range(0, 3));
         case (ph % 3)
            0:       scale = 16'h8000;
            1:       scale = 16'h7FFF;
            default: scale = 16'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0: begin
               lo = 32'h8000_0000;
               hi = 32'h7FFF_FFFF;
            end
            1: begin
               lo = 32'(-int'($urandom_range(0, 300000)));
               hi = 32'($urandom_range(0, 300000));
            end
            2: begin
               lo = 32'($urandom_range(0, 5000));
               hi = 32'(-int'($urandom_range(1, 5000)));
            end
            default: begin
               lo = $urandom;
               hi = $urandom;
            end
         endcase
         period  = (ph == 2) ? 16'hFFFF : 16'($urandom_range(0, 3));
         mask    = (ph == 3) ? 4'd0 : 4'($urandom_range(1, 15));
         offsets = {$urandom, $urandom};
         set_config(mode, scale, lo, hi, period, mask, offsets);
         if (ph == RANDOM_PHASES - 1) calm = 1'b1;

         repeat (ITEMS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               case ($urandom_range(0, 7))
                  0:       roll = 46080;
                  1:       roll = -46080;
                  2:       roll = 0;
                  default: roll = int'($urandom_range(0, 92160)) - 46080;
               endcase
               send_angle(roll);
            end else if (pick < 72) begin
               send_tick();
            end else if (pick < 86) begin
               send_contact(4'($urandom_range(0, 15)));
            end else begin
               send_load(2'($urandom_range(0, 3)),
                         ($urandom_range(0, 3) == 0) ?
                            32'(int'($urandom_range(0, 20000)) - 10000) : $urandom);
            end
         end
      end

      // Drain: everything predicted must arrive, and nothing extra after it.
      settle();
      $display("Run summary: %0d request beats over %0d register settings,",
               sent_beats, settings);
      $display("             %0d goal beats compared against prediction.", goals_seen);
      if (mismatches == 0)
         $display("servo_goal_with_contact_freeze_tb: clean");
      else
         $display("servo_goal_with_contact_freeze_tb: errors");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/sgcf_pkg.sv
rtl/core/sgcf_csr.sv
rtl/core/sgcf_front.sv
rtl/core/sgcf_queue.sv
rtl/core/sgcf_back.sv
rtl/core/servo_goal_with_contact_freeze.sv
bench/sgcf_goal_checker.sv
bench/servo_goal_with_contact_freeze_tb.sv
